>>> src/bpcs_pkg.sv
// Shared types and constants for the bicubic coefficient stencil.
package bpcs_pkg;

  localparam int unsigned MaxWidth  = 4096;
  localparam int unsigned MaxHeight = 4096;
  localparam int unsigned PixW      = 20;
  localparam int unsigned PosW      = 12;
  localparam int unsigned DimW      = 13;
  localparam int unsigned CoefW     = 29;
  localparam int unsigned TermW     = 24;
  localparam int unsigned NumBanks  = 3;
  localparam int unsigned NumCoef   = 16;
  localparam int unsigned QDepth    = 4;
  localparam int unsigned QPtrW     = 2;
  localparam int unsigned MinDim    = 3;

  typedef logic [PixW-1:0]              pix_t;
  typedef logic [PosW-1:0]              pos_t;
  typedef logic [DimW-1:0]              dim_t;
  typedef logic [3:0][3:0][PixW-1:0]    win_t;
  typedef logic signed [CoefW-1:0]      coef_t;
  typedef logic signed [TermW-1:0]      term_t;

  typedef enum logic {
    RegWidth  = 1'b0,
    RegHeight = 1'b1
  } reg_e;

  typedef struct packed {
    term_t f;
    term_t fx;
    term_t fy;
    term_t fxy;
  } pterm_t;

  typedef struct packed {
    win_t win;
    pos_t col;
    pos_t row;
    dim_t width;
    dim_t height;
    pos_t xs0;
    pos_t xs1;
    pos_t ys0;
    pos_t ys1;
    logic two_x;
    logic two_y;
  } job_t;

endpackage

>>> src/bpcs_if.sv
// Pixel and coefficient stream interfaces.
interface bpcs_pix_if;
  logic             valid;
  logic             ready;
  bpcs_pkg::pix_t   pixel_value;
  modport source (output valid, output pixel_value, input ready);
  modport sink   (input valid, input pixel_value, output ready);
endinterface

interface bpcs_coef_if;
  logic             valid;
  logic             ready;
  bpcs_pkg::pos_t   cell_column;
  bpcs_pkg::pos_t   cell_row;
  logic [3:0]       coef_index;
  bpcs_pkg::coef_t  coef_quarters;
  logic             last_of_run;
  modport source (output valid, output cell_column, output cell_row, output coef_index,
                  output coef_quarters, output last_of_run, input ready);
  modport sink   (input valid, input cell_column, input cell_row, input coef_index,
                  input coef_quarters, input last_of_run, output ready);
endinterface

>>> src/bpcs_front.sv
// Front end: config registers, line store, 4x4 window and cell job forming.
module bpcs_front (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [2:0]              paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready,
  bpcs_pix_if.sink                pix,
  input  logic [bpcs_pkg::QPtrW:0] q_count_i,
  output logic                    job_push_o,
  output bpcs_pkg::job_t          job_o
);
  import bpcs_pkg::*;

  dim_t width_q, height_q;
  pos_t col_q, row_q;
  logic [1:0] rb_q;
  logic cfg_wr;
  dim_t cfg_val;
  dim_t cfg_max;
  logic accept;
  logic last_col, last_row;
  logic [QPtrW+1:0] occ;

  logic s1_valid_q;
  pix_t s1_pix_q;
  pos_t s1_col_q, s1_row_q;
  logic [1:0] s1_rb_q;
  pix_t rd_q [NumBanks];
  win_t win_q, win_d;
  logic [1:0] b1, b2;
  logic s1_last_col, s1_last_row, has_x, has_y;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign prdata  = (reg_e'(paddr[2]) == RegHeight) ? {19'd0, height_q} : {19'd0, width_q};
  assign cfg_max = (reg_e'(paddr[2]) == RegHeight) ? dim_t'(MaxHeight) : dim_t'(MaxWidth);

  always_comb begin
    if (pwdata[12:0] < dim_t'(MinDim)) begin
      cfg_val = dim_t'(MinDim);
    end else if (pwdata[12:0] > cfg_max) begin
      cfg_val = cfg_max;
    end else begin
      cfg_val = pwdata[12:0];
    end
  end

  assign occ       = {1'b0, q_count_i} + {{(QPtrW+1){1'b0}}, s1_valid_q};
  assign pix.ready = occ < (QPtrW+2)'(QDepth);
  assign accept    = pix.valid && pix.ready;
  assign last_col  = ({1'b0, col_q} + dim_t'(1)) >= width_q;
  assign last_row  = ({1'b0, row_q} + dim_t'(1)) >= height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= dim_t'(MaxWidth);
      height_q <= dim_t'(MaxHeight);
      col_q    <= '0;
      row_q    <= '0;
      rb_q     <= '0;
    end else if (cfg_wr) begin
      if (reg_e'(paddr[2]) == RegHeight) begin
        height_q <= cfg_val;
      end else begin
        width_q <= cfg_val;
      end
      col_q <= '0;
      row_q <= '0;
      rb_q  <= '0;
    end else if (accept) begin
      if (last_col) begin
        col_q <= '0;
        if (last_row) begin
          row_q <= '0;
          rb_q  <= '0;
        end else begin
          row_q <= row_q + pos_t'(1);
          rb_q  <= (rb_q == 2'd2) ? 2'd0 : rb_q + 2'd1;
        end
      end else begin
        col_q <= col_q + pos_t'(1);
      end
    end
  end

  for (genvar k = 0; k < NumBanks; k++) begin : g_bank
    pix_t mem [MaxWidth];
    always_ff @(posedge clk_i) begin
      if (accept) begin
        rd_q[k] <= mem[col_q];
        if (rb_q == 2'(k)) begin
          mem[col_q] <= pix.pixel_value;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_pix_q <= pix.pixel_value;
      s1_col_q <= col_q;
      s1_row_q <= row_q;
      s1_rb_q  <= rb_q;
    end
    if (s1_valid_q) begin
      win_q <= win_d;
    end
  end

  assign b1 = (s1_rb_q == 2'd2) ? 2'd0 : s1_rb_q + 2'd1;
  assign b2 = (b1 == 2'd2) ? 2'd0 : b1 + 2'd1;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 3; j++) begin
        win_d[i][j] = win_q[i][j+1];
      end
    end
    win_d[0][3] = rd_q[s1_rb_q];
    win_d[1][3] = rd_q[b1];
    win_d[2][3] = rd_q[b2];
    win_d[3][3] = s1_pix_q;
  end

  assign s1_last_col = ({1'b0, s1_col_q} + dim_t'(1)) >= width_q;
  assign s1_last_row = ({1'b0, s1_row_q} + dim_t'(1)) >= height_q;
  assign has_x = s1_last_col || (s1_col_q >= pos_t'(2));
  assign has_y = s1_last_row || (s1_row_q >= pos_t'(2));

  always_comb begin
    job_o.win    = win_d;
    job_o.col    = s1_col_q;
    job_o.row    = s1_row_q;
    job_o.width  = width_q;
    job_o.height = height_q;
    job_o.two_x  = s1_last_col;
    job_o.two_y  = s1_last_row;
    if (s1_last_col) begin
      job_o.xs0 = pos_t'(width_q - dim_t'(3));
      job_o.xs1 = pos_t'(width_q - dim_t'(2));
    end else begin
      job_o.xs0 = s1_col_q - pos_t'(2);
      job_o.xs1 = s1_col_q - pos_t'(2);
    end
    if (s1_last_row) begin
      job_o.ys0 = pos_t'(height_q - dim_t'(3));
      job_o.ys1 = pos_t'(height_q - dim_t'(2));
    end else begin
      job_o.ys0 = s1_row_q - pos_t'(2);
      job_o.ys1 = s1_row_q - pos_t'(2);
    end
  end

  assign job_push_o = s1_valid_q && has_x && has_y;

endmodule

>>> src/bpcs_job_fifo.sv
// Short queue of cell jobs between the front and back ends.
module bpcs_job_fifo (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     push_i,
  input  bpcs_pkg::job_t           job_i,
  input  logic                     pop_i,
  output logic                     empty_o,
  output logic [bpcs_pkg::QPtrW:0] count_o,
  output bpcs_pkg::job_t           head_o
);
  import bpcs_pkg::*;

  job_t mem_q [QDepth];
  logic [QPtrW-1:0] wp_q, rp_q;
  logic [QPtrW:0] cnt_q;

  assign empty_o = (cnt_q == '0);
  assign count_o = cnt_q;
  assign head_o  = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wp_q <= wp_q + QPtrW'(1);
      end
      if (pop_i) begin
        rp_q <= rp_q + QPtrW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + (QPtrW+1)'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - (QPtrW+1)'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wp_q] <= job_i;
    end
  end

endmodule

>>> src/bpcs_back.sv
// Back end: point derivatives, coefficient solve and serial coefficient output.
module bpcs_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           empty_i,
  input  bpcs_pkg::job_t head_i,
  output logic           pop_o,
  bpcs_coef_if.source    coef
);
  import bpcs_pkg::*;

  typedef logic signed [31:0] acc_t;

  function automatic pix_t pxf(win_t w, logic [1:0] col, logic [1:0] row,
                               logic [1:0] c, logic [1:0] r);
    logic [1:0] i, j;
    i = row - r + 2'd3;
    j = col - c + 2'd3;
    return w[i][j];
  endfunction

  function automatic pterm_t pterms(job_t jb, pos_t gx, pos_t gy);
    pterm_t t;
    pos_t qx, qy;
    logic [1:0] c, r, xl, yl;
    logic signed [PixW+1:0] a, b, d, e;
    c = jb.col[1:0];
    r = jb.row[1:0];
    if (gx < pos_t'(1)) qx = pos_t'(1);
    else if ({1'b0, gx} > jb.width - dim_t'(2)) qx = pos_t'(jb.width - dim_t'(2));
    else qx = gx;
    if (gy < pos_t'(1)) qy = pos_t'(1);
    else if ({1'b0, gy} > jb.height - dim_t'(2)) qy = pos_t'(jb.height - dim_t'(2));
    else qy = gy;
    xl = qx[1:0];
    yl = qy[1:0];
    t.f = term_t'({2'b00, pxf(jb.win, gx[1:0], gy[1:0], c, r), 2'b00});
    a = {2'b00, pxf(jb.win, xl + 2'd1, yl, c, r)};
    b = {2'b00, pxf(jb.win, xl - 2'd1, yl, c, r)};
    t.fx = term_t'(a - b) <<< 1;
    a = {2'b00, pxf(jb.win, xl, yl + 2'd1, c, r)};
    b = {2'b00, pxf(jb.win, xl, yl - 2'd1, c, r)};
    t.fy = term_t'(a - b) <<< 1;
    a = {2'b00, pxf(jb.win, xl + 2'd1, yl + 2'd1, c, r)};
    b = {2'b00, pxf(jb.win, xl + 2'd1, yl - 2'd1, c, r)};
    d = {2'b00, pxf(jb.win, xl - 2'd1, yl + 2'd1, c, r)};
    e = {2'b00, pxf(jb.win, xl - 2'd1, yl - 2'd1, c, r)};
    t.fxy = term_t'(a) - term_t'(b) - term_t'(d) + term_t'(e);
    return t;
  endfunction

  // Stage T: point terms of one cell
  logic t_valid_q, t_last_q;
  pos_t t_x_q, t_y_q;
  pterm_t t_p_q [4];
  // Stage C: coefficients
  logic c_valid_q, c_last_q;
  pos_t c_x_q, c_y_q;
  coef_t c_a_q [NumCoef];
  // Emitter
  logic e_valid_q, e_last_q;
  pos_t e_x_q, e_y_q;
  coef_t e_a_q [NumCoef];
  logic [3:0] e_k_q;

  logic ci_q, cj_q;
  logic cell_last, t_load, c_load, e_load, e_done;
  pos_t cx, cy;
  coef_t a_d [NumCoef];

  assign e_done = e_valid_q && coef.ready && (e_k_q == 4'd15);
  assign e_load = c_valid_q && (!e_valid_q || e_done);
  assign c_load = t_valid_q && (!c_valid_q || e_load);
  assign t_load = !empty_i && (!t_valid_q || c_load);
  assign cell_last = (ci_q == head_i.two_y) && (cj_q == head_i.two_x);
  assign pop_o = t_load && cell_last;
  assign cx = cj_q ? head_i.xs1 : head_i.xs0;
  assign cy = ci_q ? head_i.ys1 : head_i.ys0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
      e_valid_q <= 1'b0;
      e_k_q     <= '0;
      ci_q      <= 1'b0;
      cj_q      <= 1'b0;
    end else begin
      if (t_load) begin
        t_valid_q <= 1'b1;
      end else if (c_load) begin
        t_valid_q <= 1'b0;
      end
      if (c_load) begin
        c_valid_q <= 1'b1;
      end else if (e_load) begin
        c_valid_q <= 1'b0;
      end
      if (e_load) begin
        e_valid_q <= 1'b1;
        e_k_q     <= '0;
      end else if (e_valid_q && coef.ready) begin
        e_k_q <= e_k_q + 4'd1;
        if (e_k_q == 4'd15) begin
          e_valid_q <= 1'b0;
        end
      end
      if (t_load) begin
        if (cell_last) begin
          ci_q <= 1'b0;
          cj_q <= 1'b0;
        end else if (cj_q == head_i.two_x) begin
          cj_q <= 1'b0;
          ci_q <= 1'b1;
        end else begin
          cj_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (t_load) begin
      t_x_q    <= cx;
      t_y_q    <= cy;
      t_last_q <= cell_last;
      t_p_q[0] <= pterms(head_i, cx, cy);
      t_p_q[1] <= pterms(head_i, cx + pos_t'(1), cy);
      t_p_q[2] <= pterms(head_i, cx, cy + pos_t'(1));
      t_p_q[3] <= pterms(head_i, cx + pos_t'(1), cy + pos_t'(1));
    end
    if (c_load) begin
      c_x_q    <= t_x_q;
      c_y_q    <= t_y_q;
      c_last_q <= t_last_q;
      c_a_q    <= a_d;
    end
    if (e_load) begin
      e_x_q    <= c_x_q;
      e_y_q    <= c_y_q;
      e_last_q <= c_last_q;
      e_a_q    <= c_a_q;
    end
  end

  always_comb begin
    acc_t f00, f10, f01, f11, x00, x10, x01, x11;
    acc_t y00, y10, y01, y11, z00, z10, z01, z11, s;
    acc_t a [NumCoef];
    f00 = acc_t'(t_p_q[0].f);   f10 = acc_t'(t_p_q[1].f);
    f01 = acc_t'(t_p_q[2].f);   f11 = acc_t'(t_p_q[3].f);
    x00 = acc_t'(t_p_q[0].fx);  x10 = acc_t'(t_p_q[1].fx);
    x01 = acc_t'(t_p_q[2].fx);  x11 = acc_t'(t_p_q[3].fx);
    y00 = acc_t'(t_p_q[0].fy);  y10 = acc_t'(t_p_q[1].fy);
    y01 = acc_t'(t_p_q[2].fy);  y11 = acc_t'(t_p_q[3].fy);
    z00 = acc_t'(t_p_q[0].fxy); z10 = acc_t'(t_p_q[1].fxy);
    z01 = acc_t'(t_p_q[2].fxy); z11 = acc_t'(t_p_q[3].fxy);
    s = f00 - f10 - f01 + f11;
    a[0]  = f00;
    a[1]  = x00;
    a[2]  = -3 * f00 + 3 * f10 - 2 * x00 - x10;
    a[3]  = 2 * f00 - 2 * f10 + x00 + x10;
    a[4]  = y00;
    a[5]  = z00;
    a[6]  = -3 * y00 + 3 * y10 - 2 * z00 - z10;
    a[7]  = 2 * y00 - 2 * y10 + z00 + z10;
    a[8]  = -3 * f00 + 3 * f01 - 2 * y00 - y01;
    a[9]  = -3 * x00 + 3 * x01 - 2 * z00 - z01;
    a[10] = 9 * s + 6 * x00 + 3 * x10 - 6 * x01 - 3 * x11
          + 6 * y00 - 6 * y10 + 3 * y01 - 3 * y11
          + 4 * z00 + 2 * z10 + 2 * z01 + z11;
    a[11] = -6 * s - 3 * x00 - 3 * x10 + 3 * x01 + 3 * x11
          - 4 * y00 + 4 * y10 - 2 * y01 + 2 * y11
          - 2 * z00 - 2 * z10 - z01 - z11;
    a[12] = 2 * f00 - 2 * f01 + y00 + y01;
    a[13] = 2 * x00 - 2 * x01 + z00 + z01;
    a[14] = -6 * s - 4 * x00 - 2 * x10 + 4 * x01 + 2 * x11
          - 3 * y00 + 3 * y10 - 3 * y01 + 3 * y11
          - 2 * z00 - z10 - 2 * z01 - z11;
    a[15] = 4 * s + 2 * x00 + 2 * x10 - 2 * x01 - 2 * x11
          + 2 * y00 - 2 * y10 + 2 * y01 - 2 * y11
          + z00 + z10 + z01 + z11;
    for (int k = 0; k < NumCoef; k++) begin
      a_d[k] = coef_t'(a[k]);
    end
  end

  assign coef.valid         = e_valid_q;
  assign coef.cell_column   = e_x_q;
  assign coef.cell_row      = e_y_q;
  assign coef.coef_index    = e_k_q;
  assign coef.coef_quarters = e_a_q[e_k_q];
  assign coef.last_of_run   = e_last_q && (e_k_q == 4'd15);

endmodule

>>> src/bicubic_patch_coefficient_stencil.sv
// Top level of the bicubic patch coefficient stencil.
// Pixels stream in raster order, one transfer per pixel; each pixel that closes a cell yields
// 16 coefficient transfers (a00, a10 .. a33), 32 or 64 at the last column or row, and none in
// the first two rows and columns. The output emits one coefficient per cycle while the sink
// holds ready high; the input accepts a new pixel every cycle while the four-entry job queue
// has room, and the output stage sets the sustained rate. Pixels pass the s1 registers, the
// job queue, stages T and C and the emitter. Writing either size register restarts the frame;
// registers must be written only while the block is idle, which the block does not enforce.
module bicubic_patch_coefficient_stencil (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  bpcs_pix_if.sink    pix,
  bpcs_coef_if.source coef
);
  import bpcs_pkg::*;

  logic             push, pop, empty;
  logic [QPtrW:0]   count;
  job_t             job, head;

  bpcs_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .pix       (pix),
    .q_count_i (count),
    .job_push_o(push),
    .job_o     (job)
  );

  bpcs_job_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .job_i  (job),
    .pop_i  (pop),
    .empty_o(empty),
    .count_o(count),
    .head_o (head)
  );

  bpcs_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .empty_i(empty),
    .head_i (head),
    .pop_o  (pop),
    .coef   (coef)
  );

endmodule

>>> tb/sv/bicubic_patch_coefficient_stencil_tb.sv
// Testbench for the bicubic patch coefficient stencil: random streams checked against a predictor.
module bicubic_patch_coefficient_stencil_tb;
  import bpcs_pkg::*;

  localparam int unsigned IdlePct  = 35;
  localparam int unsigned StallMax = 20000;

  typedef struct {
    pos_t       col;
    pos_t       row;
    logic [3:0] idx;
    coef_t      q;
    logic       last;
  } coef_exp_t;

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  bpcs_pix_if  pix_bus ();
  bpcs_coef_if coef_bus ();

  bicubic_patch_coefficient_stencil uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .pix     (pix_bus.sink),
    .coef    (coef_bus.source)
  );

  pix_t      pixel_fifo[$];
  coef_exp_t coef_fifo[$];
  int        errors;
  int        stall_cycles;
  int        cycle_no;
  bit        calm;

  logic [PixW-1:0] line_rows[NumBanks*MaxWidth];
  logic [PixW-1:0] win[4][4];
  int              col_cnt;
  int              row_cnt;
  int              img_w;
  int              img_h;

  function automatic int clip(int v, int lo, int hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint pel(int col, int row, int c, int r);
    return longint'(win[(row - r + 3) & 3][(col - c + 3) & 3]);
  endfunction

  function automatic void add_pixel(pix_t v);
    pixel_fifo = {pixel_fifo, v};
  endfunction

  function automatic void grid_terms(int gx, int gy, int c, int r, output longint t[4]);
    int qx;
    int qy;
    qx = clip(gx, 1, img_w - 2);
    qy = clip(gy, 1, img_h - 2);
    t[0] = 4 * pel(gx, gy, c, r);
    t[1] = 2 * (pel(qx + 1, qy, c, r) - pel(qx - 1, qy, c, r));
    t[2] = 2 * (pel(qx, qy + 1, c, r) - pel(qx, qy - 1, c, r));
    t[3] = pel(qx + 1, qy + 1, c, r) - pel(qx + 1, qy - 1, c, r)
         - pel(qx - 1, qy + 1, c, r) + pel(qx - 1, qy - 1, c, r);
  endfunction

  function automatic void cell_coefs(int x, int y, int c, int r, output longint a[16]);
    longint p00[4], p10[4], p01[4], p11[4];
    longint f00, f10, f01, f11, x00, x10, x01, x11;
    longint y00, y10, y01, y11, z00, z10, z01, z11, fs;
    grid_terms(x, y, c, r, p00);
    grid_terms(x + 1, y, c, r, p10);
    grid_terms(x, y + 1, c, r, p01);
    grid_terms(x + 1, y + 1, c, r, p11);
    f00 = p00[0]; f10 = p10[0]; f01 = p01[0]; f11 = p11[0];
    x00 = p00[1]; x10 = p10[1]; x01 = p01[1]; x11 = p11[1];
    y00 = p00[2]; y10 = p10[2]; y01 = p01[2]; y11 = p11[2];
    z00 = p00[3]; z10 = p10[3]; z01 = p01[3]; z11 = p11[3];
    fs = f00 - f10 - f01 + f11;
    a[0] = f00;
    a[1] = x00;
    a[2] = -3 * f00 + 3 * f10 - 2 * x00 - x10;
    a[3] = 2 * f00 - 2 * f10 + x00 + x10;
    a[4] = y00;
    a[5] = z00;
    a[6] = -3 * y00 + 3 * y10 - 2 * z00 - z10;
    a[7] = 2 * y00 - 2 * y10 + z00 + z10;
    a[8] = -3 * f00 + 3 * f01 - 2 * y00 - y01;
    a[9] = -3 * x00 + 3 * x01 - 2 * z00 - z01;
    a[10] = 9 * fs + 6 * x00 + 3 * x10 - 6 * x01 - 3 * x11
          + 6 * y00 - 6 * y10 + 3 * y01 - 3 * y11
          + 4 * z00 + 2 * z10 + 2 * z01 + z11;
    a[11] = -6 * fs - 3 * x00 - 3 * x10 + 3 * x01 + 3 * x11
          - 4 * y00 + 4 * y10 - 2 * y01 + 2 * y11
          - 2 * z00 - 2 * z10 - z01 - z11;
    a[12] = 2 * f00 - 2 * f01 + y00 + y01;
    a[13] = 2 * x00 - 2 * x01 + z00 + z01;
    a[14] = -6 * fs - 4 * x00 - 2 * x10 + 4 * x01 + 2 * x11
          - 3 * y00 + 3 * y10 - 3 * y01 + 3 * y11
          - 2 * z00 - z10 - 2 * z01 - z11;
    a[15] = 4 * fs + 2 * x00 + 2 * x10 - 2 * x01 - 2 * x11
          + 2 * y00 - 2 * y10 + 2 * y01 - 2 * y11
          + z00 + z10 + z01 + z11;
  endfunction

  task automatic predict_coefs(pix_t v);
    int        c;
    int        r;
    int        ys[2];
    int        xs[2];
    int        ny;
    int        nx;
    int        n;
    longint    a[16];
    coef_exp_t e;
    c  = col_cnt;
    r  = row_cnt;
    ny = 0;
    nx = 0;
    n  = 0;
    for (int i = 0; i < 4; i++)
      for (int j = 0; j < 3; j++)
        win[i][j] = win[i][j+1];
    win[0][3] = line_rows[(r % 3) * MaxWidth + c];
    win[1][3] = line_rows[((r + 1) % 3) * MaxWidth + c];
    win[2][3] = line_rows[((r + 2) % 3) * MaxWidth + c];
    win[3][3] = v;
    line_rows[(r % 3) * MaxWidth + c] = v;
    if (r + 1 >= img_h) begin
      ys[0] = img_h - 3; ys[1] = img_h - 2; ny = 2;
    end else if (r >= 2) begin
      ys[0] = r - 2; ny = 1;
    end
    if (c + 1 >= img_w) begin
      xs[0] = img_w - 3; xs[1] = img_w - 2; nx = 2;
    end else if (c >= 2) begin
      xs[0] = c - 2; nx = 1;
    end
    for (int i = 0; i < ny; i++)
      for (int j = 0; j < nx; j++) begin
        cell_coefs(xs[j], ys[i], c, r, a);
        for (int k = 0; k < NumCoef; k++) begin
          e.col  = pos_t'(xs[j]);
          e.row  = pos_t'(ys[i]);
          e.idx  = 4'(k);
          e.q    = coef_t'(a[k]);
          e.last = 1'b0;
          coef_fifo = {coef_fifo, e};
          n++;
        end
      end
    if (n > 0) coef_fifo[coef_fifo.size()-1].last = 1'b1;
    if (c + 1 >= img_w) begin
      col_cnt = 0;
      row_cnt = (r + 1 >= img_h) ? 0 : r + 1;
    end else begin
      col_cnt = c + 1;
    end
  endtask

  task automatic reg_write(reg_e idx, logic [31:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 3'(int'(idx) * 4);
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (idx == RegWidth) img_w = clip(int'(value[DimW-1:0]), MinDim, MaxWidth);
    else                 img_h = clip(int'(value[DimW-1:0]), MinDim, MaxHeight);
    col_cnt = 0;
    row_cnt = 0;
  endtask

  // sample between edges so queue and handshake updates have settled
  task automatic drain();
    while (pixel_fifo.size() != 0 || pix_bus.valid || coef_fifo.size() != 0)
      @(negedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  task automatic frame_setup(int w, int h);
    drain();
    reg_write(RegWidth, w);
    reg_write(RegHeight, h);
  endtask

  task automatic push_random(int count);
    for (int i = 0; i < count; i++)
      case ($urandom % 8)
        0:       add_pixel('0);
        1:       add_pixel('1);
        default: add_pixel(pix_t'($urandom_range(0, 20'hFFFFF)));
      endcase
  endtask

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    rst_ni  = 1'b0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    pix_bus.valid       = 1'b0;
    pix_bus.pixel_value = '0;
    coef_bus.ready      = 1'b0;
    errors  = 0;
    col_cnt = 0;
    row_cnt = 0;
    img_w   = MaxWidth;
    img_h   = MaxHeight;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // out-of-range sizes clamp to the largest width and smallest height
    frame_setup(8191, 0);
    push_random(12);

    frame_setup(MinDim, MinDim);
    add_pixel('0);
    add_pixel('1);
    add_pixel(20'h55555);
    add_pixel(20'hAAAAA);
    add_pixel('1);
    add_pixel('0);
    add_pixel('1);
    add_pixel('0);
    add_pixel(20'h80000);
    for (int i = 0; i < 9; i++) add_pixel((i % 2) ? '0 : '1);
    push_random(9);

    frame_setup(5, 4);
    push_random(20);
    drain();
    push_random(20);

    frame_setup(7, 6);
    push_random(42);

    frame_setup(4, 3);
    push_random(24);

    frame_setup(3, 5);
    push_random(30);

    frame_setup(MaxWidth, MinDim);
    push_random(8);

    drain();
    repeat (20) @(posedge clk_i);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      cycle_no <= cycle_no + 1;
      calm     <= (cycle_no > 1500 && cycle_no < 2500);
    end else begin
      cycle_no <= 0;
      calm     <= 1'b0;
    end
  end

  // pixel driver
  always @(posedge clk_i) begin
    if (rst_ni && (!pix_bus.valid || pix_bus.ready)) begin
      if (pixel_fifo.size() != 0 && (calm || $urandom_range(0, 99) >= IdlePct)) begin
        pix_bus.valid       <= 1'b1;
        pix_bus.pixel_value <= pixel_fifo.pop_front();
      end else begin
        pix_bus.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && pix_bus.valid && pix_bus.ready) predict_coefs(pix_bus.pixel_value);
  end

  // coefficient monitor
  always @(posedge clk_i) begin
    coef_exp_t e;
    if (rst_ni) begin
      coef_bus.ready <= calm || ($urandom_range(0, 99) >= IdlePct);
      if (coef_bus.valid && coef_bus.ready) begin
        if (coef_fifo.size() == 0) begin
          $error("unexpected coefficient transfer");
          errors++;
        end else begin
          e = coef_fifo.pop_front();
          if (coef_bus.cell_column !== e.col) begin
            $error("cell_column exp %0d got %0d", e.col, coef_bus.cell_column); errors++;
          end
          if (coef_bus.cell_row !== e.row) begin
            $error("cell_row exp %0d got %0d", e.row, coef_bus.cell_row); errors++;
          end
          if (coef_bus.coef_index !== e.idx) begin
            $error("coef_index exp %0d got %0d", e.idx, coef_bus.coef_index); errors++;
          end
          if (coef_bus.coef_quarters !== e.q) begin
            $error("coef_quarters exp %0d got %0d", e.q, coef_bus.coef_quarters); errors++;
          end
          if (coef_bus.last_of_run !== e.last) begin
            $error("last_of_run exp %0d got %0d", e.last, coef_bus.last_of_run); errors++;
          end
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if (!rst_ni || (pix_bus.valid && pix_bus.ready) || (coef_bus.valid && coef_bus.ready)
        || psel) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= StallMax) begin
      $display("FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

endmodule
